@@ rtl/rbs_pkg.sv @@
// Shared types and constants of the request batch scheduler.
// Depends on nothing; the configuration registers, front end, engine and top unit import it.
package rbs_pkg;

  // Command codes on the input channel
  localparam logic [2:0] OP_SUBMIT = 3'd0;
  localparam logic [2:0] OP_STEP   = 3'd1;
  localparam logic [2:0] OP_TOKEN  = 3'd2;
  localparam logic [2:0] OP_FINISH = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  // Request status codes
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_DECODING = 3'd2;
  localparam logic [2:0] ST_FINISHED = 3'd3;
  localparam logic [2:0] ST_ERROR    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_BATCH_LIMIT = 2'd0;
  localparam logic [1:0] REG_QUEUE_LIMIT = 2'd1;
  localparam logic [1:0] REG_DEFAULT_NEW = 2'd2;
  localparam logic [1:0] REG_EOS_TOKEN   = 2'd3;

  // Register reset values
  localparam logic [4:0]  BATCH_LIMIT_RST = 5'd8;
  localparam logic [8:0]  QUEUE_LIMIT_RST = 9'd256;
  localparam logic [15:0] DEFAULT_NEW_RST = 16'd256;
  localparam logic [18:0] EOS_TOKEN_RST   = 19'h7FFFF;

  // Substitutes for a zero register value
  localparam logic [4:0] BATCH_ZERO_CAP = 5'd8;
  localparam logic [8:0] QUEUE_ZERO_CAP = 9'd256;

  typedef enum logic [2:0] {
    K_SUBMIT, K_STEP, K_TOKEN, K_FINISH, K_QUERY, K_BAD
  } kind_t;

  typedef struct packed {
    logic [4:0]         batch_limit;
    logic [8:0]         queue_limit;
    logic [15:0]        default_new_tokens;
    logic signed [18:0] eos_token;
  } cfg_t;

  // Classified command handed from front to engine
  typedef struct packed {
    kind_t       kind;
    logic [23:0] req_id;
    logic [15:0] prompt_len;
    logic [15:0] limit;
    logic [17:0] token;
  } cmd_t;

endpackage

@@ rtl/rbs_channels.sv @@
// Handshake channels of the request batch scheduler: command in, response out.
// Depends on nothing.
interface rbs_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [23:0] req_id;
  logic [15:0] prompt_len;
  logic [15:0] max_new;
  logic [17:0] token;

  modport source(output valid, op, req_id, prompt_len, max_new, token, input ready);
  modport sink(input valid, op, req_id, prompt_len, max_new, token, output ready);
endinterface

interface rbs_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [23:0] result_id;
  logic [2:0]  status;
  logic [15:0] generated;
  logic [16:0] position;
  logic [4:0]  batch_count;
  logic [8:0]  waiting_count;
  logic [31:0] completed_total;
  logic [47:0] tokens_total;

  modport source(output valid, ok, result_id, status, generated, position, batch_count,
                 waiting_count, completed_total, tokens_total, input ready);
  modport sink(input valid, ok, result_id, status, generated, position, batch_count,
               waiting_count, completed_total, tokens_total, output ready);
endinterface

@@ rtl/rbs_cfg_regs.sv @@
// APB configuration registers of the request batch scheduler.
// Depends on rbs_pkg.
module rbs_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rbs_pkg::cfg_t cfg
);
  import rbs_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.batch_limit        <= BATCH_LIMIT_RST;
      cfg.queue_limit        <= QUEUE_LIMIT_RST;
      cfg.default_new_tokens <= DEFAULT_NEW_RST;
      cfg.eos_token          <= EOS_TOKEN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_BATCH_LIMIT: cfg.batch_limit        <= pwdata[4:0];
        REG_QUEUE_LIMIT: cfg.queue_limit        <= pwdata[8:0];
        REG_DEFAULT_NEW: cfg.default_new_tokens <= pwdata[15:0];
        REG_EOS_TOKEN:   cfg.eos_token          <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  // Read back, end token sign-extended
  always_comb begin
    unique case (idx)
      REG_BATCH_LIMIT: prdata = {27'd0, cfg.batch_limit};
      REG_QUEUE_LIMIT: prdata = {23'd0, cfg.queue_limit};
      REG_DEFAULT_NEW: prdata = {16'd0, cfg.default_new_tokens};
      REG_EOS_TOKEN:   prdata = {{13{cfg.eos_token[18]}}, cfg.eos_token};
      default:         prdata = '0;
    endcase
  end

endmodule

@@ rtl/rbs_front.sv @@
// Front end: accepts command transactions, classifies them and queues them
// in a two-entry buffer for the engine. Depends on rbs_pkg and rbs_cmd_if.
module rbs_front (
  input  logic           clk,
  input  logic           rst,
  rbs_cmd_if.sink        cmd,
  input  logic [15:0]    default_new_tokens,
  output logic           q_valid,
  output rbs_pkg::cmd_t  q_data,
  input  logic           q_pop
);
  import rbs_pkg::*;

  cmd_t       buf_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid & cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_data    = buf_mem[rd_ptr];

  // Classify the op and resolve a zero token limit
  always_comb begin
    cls.req_id     = cmd.req_id;
    cls.prompt_len = cmd.prompt_len;
    cls.limit      = (cmd.max_new != 16'd0) ? cmd.max_new : default_new_tokens;
    cls.token      = cmd.token;
    unique case (cmd.op)
      OP_SUBMIT: cls.kind = K_SUBMIT;
      OP_STEP:   cls.kind = K_STEP;
      OP_TOKEN:  cls.kind = K_TOKEN;
      OP_FINISH: cls.kind = K_FINISH;
      OP_QUERY:  cls.kind = K_QUERY;
      default:   cls.kind = K_BAD;
    endcase
  end

  // Store incoming transactions
  always_ff @(posedge clk) begin
    if (push) buf_mem[wr_ptr] <= cls;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop && q_valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

endmodule

@@ rtl/rbs_engine.sv @@
// Back end: waiting ring in a memory, batch slot table, counters and the
// sequencer that executes one command at a time. Depends on rbs_pkg, rbs_rsp_if.
module rbs_engine #(
  parameter int BATCH_SLOTS = 16,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  rbs_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  rbs_pkg::cmd_t q_data,
  output logic          q_pop,
  rbs_rsp_if.source     rsp
);
  import rbs_pkg::*;

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW  = (CW > 9) ? CW : 9;
  localparam int SI    = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
  localparam int SW    = $clog2(BATCH_SLOTS + 1);
  localparam int BCMPW = (SW > 5) ? SW : 5;
  localparam int RECW  = 56;

  typedef enum logic [3:0] {
    S_IDLE, S_QRD, S_QCMP, S_BSCAN, S_STEP_RD, S_STEP_WR, S_TOKEN, S_FIN_MOVE, S_OUT
  } state_t;

  state_t state;
  cmd_t   c;

  // Waiting ring
  logic [RECW-1:0] qmem [QUEUE_DEPTH];
  logic [RECW-1:0] q_rd_data;
  logic [AW-1:0]   head, tail, qidx;
  logic [CW-1:0]   wcount, qi;
  logic            q_we;

  // Batch slots
  logic [23:0] sid   [BATCH_SLOTS];
  logic [2:0]  sst   [BATCH_SLOTS];
  logic [15:0] slim  [BATCH_SLOTS];
  logic [15:0] splen [BATCH_SLOTS];
  logic [15:0] sgen  [BATCH_SLOTS];
  logic [16:0] spos  [BATCH_SLOTS];
  logic [SW-1:0] scount, si;
  logic [SW-1:0] last;
  logic [SI-1:0] rd_i;

  // Counters
  logic [23:0] next_id;
  logic [31:0] done_count;
  logic [47:0] token_sum;

  // Partial result of the command in flight
  logic        r_ok;
  logic [23:0] r_id;
  logic [2:0]  r_st;
  logic [15:0] r_gen;
  logic [16:0] r_pos;

  // Output register
  logic        ovalid;

  // Effective capacities
  logic [CMPW-1:0]  qsel, qcap;
  logic [BCMPW-1:0] bsel, bcap;
  logic [CMPW-1:0]  wc_ext;
  logic [BCMPW-1:0] sc_ext;

  // Token report arithmetic
  logic [15:0] t_gen;
  logic [16:0] t_pos;
  logic        t_fin;

  logic        submit_ok;
  logic        out_free;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx,
                                              input logic [CMPW-1:0] cap);
    logic [CMPW-1:0] n;
    n = CMPW'(idx) + 1'b1;
    return (n >= cap) ? '0 : AW'(n);
  endfunction

  always_comb begin
    qsel = (cfg.queue_limit == 9'd0) ? CMPW'(QUEUE_ZERO_CAP) : CMPW'(cfg.queue_limit);
    qcap = (qsel > CMPW'(QUEUE_DEPTH)) ? CMPW'(QUEUE_DEPTH) : qsel;
    bsel = (cfg.batch_limit == 5'd0) ? BCMPW'(BATCH_ZERO_CAP) : BCMPW'(cfg.batch_limit);
    bcap = (bsel > BCMPW'(BATCH_SLOTS)) ? BCMPW'(BATCH_SLOTS) : bsel;
    wc_ext = CMPW'(wcount);
    sc_ext = BCMPW'(scount);
  end

  assign last      = scount - 1'b1;
  assign rd_i      = (state == S_FIN_MOVE) ? last[SI-1:0] : si[SI-1:0];
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign submit_ok = (q_data.prompt_len != 16'd0) && (wc_ext < qcap);
  assign q_we      = q_pop && (q_data.kind == K_SUBMIT) && submit_ok;
  assign out_free  = !ovalid || rsp.ready;

  // Next generated count and position for a token report at slot si
  always_comb begin
    t_gen = sgen[rd_i] + 16'd1;
    t_pos = (sgen[rd_i] == 16'd0) ? {1'b0, splen[rd_i]} : spos[rd_i] + 17'd1;
    t_fin = (!cfg.eos_token[18] && ({1'b0, c.token} == cfg.eos_token)) ||
            (t_gen >= slim[rd_i]);
  end

  // Ring memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (q_we) qmem[tail] <= {next_id, q_data.prompt_len, q_data.limit};
    q_rd_data <= qmem[qidx];
  end

  // Slot table updates
  always_ff @(posedge clk) begin
    unique case (state)
      S_STEP_WR: begin
        sid[scount[SI-1:0]]   <= q_rd_data[55:32];
        splen[scount[SI-1:0]] <= q_rd_data[31:16];
        slim[scount[SI-1:0]]  <= q_rd_data[15:0];
        sgen[scount[SI-1:0]]  <= 16'd0;
        spos[scount[SI-1:0]]  <= 17'd0;
        sst[scount[SI-1:0]]   <= ST_DECODING;
      end
      S_TOKEN: begin
        sgen[rd_i] <= t_gen;
        spos[rd_i] <= t_pos;
        if (t_fin) sst[rd_i] <= ST_FINISHED;
      end
      S_FIN_MOVE: begin
        sid[si[SI-1:0]]   <= sid[rd_i];
        splen[si[SI-1:0]] <= splen[rd_i];
        slim[si[SI-1:0]]  <= slim[rd_i];
        sgen[si[SI-1:0]]  <= sgen[rd_i];
        spos[si[SI-1:0]]  <= spos[rd_i];
        sst[si[SI-1:0]]   <= sst[rd_i];
      end
      default: ;
    endcase
  end

  // Sequencer and registered response
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      wcount     <= '0;
      scount     <= '0;
      next_id    <= 24'd1;
      done_count <= '0;
      token_sum  <= '0;
      ovalid     <= 1'b0;
      qidx       <= '0;
      qi         <= '0;
      si         <= '0;
    end else begin
      // Drop a taken response unless a new one is loaded below
      if (rsp.ready && state != S_OUT) ovalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            c     <= q_data;
            r_id  <= q_data.req_id;
            r_gen <= 16'd0;
            r_pos <= 17'd0;
            r_ok  <= 1'b0;
            r_st  <= ST_ERROR;
            qidx  <= head;
            qi    <= '0;
            si    <= '0;
            unique case (q_data.kind)
              K_SUBMIT: begin
                state <= S_OUT;
                if (submit_ok) begin
                  r_ok    <= 1'b1;
                  r_st    <= ST_QUEUED;
                  r_id    <= next_id;
                  next_id <= (next_id == 24'hFFFFFF) ? 24'd1 : next_id + 24'd1;
                  tail    <= ring_next(tail, qcap);
                  wcount  <= wcount + 1'b1;
                end else begin
                  r_id <= 24'd0;
                end
              end
              K_STEP: begin
                r_ok  <= 1'b1;
                r_st  <= ST_QUEUED;
                r_id  <= 24'd0;
                state <= S_STEP_RD;
              end
              K_TOKEN, K_QUERY: state <= (wcount != '0) ? S_QRD : S_BSCAN;
              K_FINISH:         state <= S_BSCAN;
              default: begin
                r_id  <= 24'd0;
                state <= S_OUT;
              end
            endcase
          end
        end
        // Wait for the ring entry at qidx
        S_QRD: state <= S_QCMP;
        S_QCMP: begin
          if (q_rd_data[55:32] == c.req_id) begin
            if (c.kind == K_QUERY) begin
              r_ok <= 1'b1;
              r_st <= ST_QUEUED;
            end
            state <= S_OUT;
          end else if (qi + 1'b1 >= wcount) begin
            state <= S_BSCAN;
          end else begin
            qi    <= qi + 1'b1;
            qidx  <= ring_next(qidx, qcap);
            state <= S_QRD;
          end
        end
        // Walk the occupied slots in order
        S_BSCAN: begin
          if (si >= scount) begin
            state <= S_OUT;
          end else if (sid[rd_i] == c.req_id) begin
            unique case (c.kind)
              K_QUERY: begin
                r_ok  <= 1'b1;
                r_st  <= sst[rd_i];
                r_gen <= sgen[rd_i];
                r_pos <= spos[rd_i];
                state <= S_OUT;
              end
              K_TOKEN: state <= (sst[rd_i] == ST_DECODING) ? S_TOKEN : S_OUT;
              default: begin
                r_ok       <= 1'b1;
                r_st       <= ST_FINISHED;
                r_gen      <= sgen[rd_i];
                r_pos      <= spos[rd_i];
                done_count <= done_count + 32'd1;
                token_sum  <= token_sum + {32'd0, sgen[rd_i]};
                state      <= S_FIN_MOVE;
              end
            endcase
          end else begin
            si <= si + 1'b1;
          end
        end
        S_TOKEN: begin
          r_ok  <= 1'b1;
          r_st  <= t_fin ? ST_FINISHED : sst[rd_i];
          r_gen <= t_gen;
          r_pos <= t_pos;
          state <= S_OUT;
        end
        S_FIN_MOVE: begin
          scount <= last;
          state  <= S_OUT;
        end
        // Admit the oldest waiting request while a slot is free
        S_STEP_RD: begin
          if (wcount != '0 && sc_ext < bcap) state <= S_STEP_WR;
          else state <= S_OUT;
        end
        S_STEP_WR: begin
          head   <= ring_next(head, qcap);
          qidx   <= ring_next(head, qcap);
          wcount <= wcount - 1'b1;
          scount <= scount + 1'b1;
          state  <= S_STEP_RD;
        end
        S_OUT: begin
          if (out_free) begin
            ovalid              <= 1'b1;
            rsp.ok              <= r_ok;
            rsp.result_id       <= r_id;
            rsp.status          <= r_st;
            rsp.generated       <= r_gen;
            rsp.position        <= r_pos;
            rsp.batch_count     <= sc_ext[4:0];
            rsp.waiting_count   <= wc_ext[8:0];
            rsp.completed_total <= done_count;
            rsp.tokens_total    <= token_sum;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = ovalid;

`ifndef SYNTHESIS
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    scount <= SW'(BATCH_SLOTS)) else $error("slot count beyond table");
  a_wait_bound: assert property (@(posedge clk) disable iff (rst)
    wcount <= CW'(QUEUE_DEPTH)) else $error("waiting count beyond ring");
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> (rsp.ok == (rsp.status != ST_ERROR))) else $error("ok and status disagree");
  a_id_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_id != 24'd0) else $error("next id is zero");
  a_step_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP_WR |=> scount == $past(scount) + 1'b1) else $error("admit lost a slot");
`endif

endmodule

@@ rtl/request_batch_scheduler_unit.sv @@
// Usage of the request batch scheduler.
// Command channel cmd (op, req_id, prompt_len, max_new, token) and response
// channel rsp: valid/ready, a transaction moves when both are high. Every
// command gives exactly one response, in command order.
// Configuration: APB write of the batch limit, queue_limit, default_new_tokens,
// eos_token at byte addresses 0, 4, 8, 12; write only while idle.
// Command handling: submit and bad ops go straight to the response; step
// admits the oldest waiting request into a free slot, one at a time, while
// any wait; token report and query search the waiting ring (one registered
// memory read per entry examined) and then the occupied slots, and a token
// report that finds its request decoding updates that slot; finish searches
// the occupied slots and moves the last one into the freed slot. The engine
// starts a new command only after loading the previous response for output.
// A two-entry front buffer accepts commands while the engine works, and the
// output register holds a response while the receiver stalls; the engine then
// waits before starting the next command.
// Reset clears occupancy, pointers and counters and sets the next id to 1; no
// clearing pass runs over the ring memory or the slot table.
// Depends on rbs_pkg, rbs_channels, rbs_cfg_regs, rbs_front, rbs_engine.
module request_batch_scheduler_unit #(
  parameter int BATCH_SLOTS = 16,
  parameter int QUEUE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  rbs_cmd_if.sink     cmd,
  rbs_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rbs_pkg::*;

  cfg_t cfg;
  logic q_valid;
  cmd_t q_data;
  logic q_pop;

  rbs_cfg_regs u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  rbs_front u_front (
    .clk, .rst, .cmd,
    .default_new_tokens(cfg.default_new_tokens),
    .q_valid, .q_data, .q_pop
  );

  rbs_engine #(.BATCH_SLOTS(BATCH_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
    .clk, .rst, .cfg, .q_valid, .q_data, .q_pop, .rsp
  );

endmodule
